@@ design/q16div_pkg.sv @@
`timescale 1ns / 1ps

package q16div_pkg;

    localparam int WordW = 32;

    // One in-flight division request, carried from stage to stage.
    typedef struct packed {
        logic             valid;
        logic             neg;     // operand signs differ
        logic             dz;      // divisor was zero
        logic [WordW-1:0] dvd;     // dividend magnitude, shifted out MSB first
        logic [WordW-1:0] dsr;     // divisor magnitude
        logic [WordW-1:0] rem;     // partial remainder, below dsr whenever dsr is nonzero
        logic [WordW-1:0] quo;     // low quotient bits collected so far
    } t_div_req;

endpackage

@@ design/q16div_prep.sv @@
`timescale 1ns / 1ps

module q16div_prep (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic signed [q16div_pkg::WordW-1:0] i_dividend,
    input  logic signed [q16div_pkg::WordW-1:0] i_divisor,
    output q16div_pkg::t_div_req              o_req
);

    // Two's complement magnitude; the most negative value maps to 2^31 unsigned.
    function automatic logic [q16div_pkg::WordW-1:0] magnitude(
        input logic [q16div_pkg::WordW-1:0] v
    );
        magnitude = v[q16div_pkg::WordW-1] ? (~v + 1'b1) : v;
    endfunction

    q16div_pkg::t_div_req r_req;
    q16div_pkg::t_div_req n_req;

    always_comb begin
        n_req.valid = i_accept;
        n_req.neg   = i_dividend[q16div_pkg::WordW-1] ^ i_divisor[q16div_pkg::WordW-1];
        n_req.dz    = (i_divisor == '0);
        n_req.dvd   = magnitude(i_dividend);
        n_req.dsr   = magnitude(i_divisor);
        n_req.rem   = '0;
        n_req.quo   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.valid <= 1'b0;
        end else begin
            r_req.valid <= n_req.valid;
        end
        r_req.neg <= n_req.neg;
        r_req.dz  <= n_req.dz;
        r_req.dvd <= n_req.dvd;
        r_req.dsr <= n_req.dsr;
        r_req.rem <= n_req.rem;
        r_req.quo <= n_req.quo;
    end

    assign o_req = r_req;

endmodule

@@ design/q16div_stage.sv @@
`timescale 1ns / 1ps

// One restoring step: shift in the next dividend bit, try to subtract.
module q16div_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  q16div_pkg::t_div_req i_req,
    output q16div_pkg::t_div_req o_req
);

    localparam int W = q16div_pkg::WordW;

    q16div_pkg::t_div_req r_req;
    q16div_pkg::t_div_req n_req;

    logic [W:0]   w_shift;
    logic [W+1:0] w_diff;
    logic         w_ge;

    always_comb begin
        w_shift = {i_req.rem, i_req.dvd[W-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, i_req.dsr};
        w_ge    = ~w_diff[W+1];

        n_req       = i_req;
        n_req.dvd   = {i_req.dvd[W-2:0], 1'b0};
        n_req.rem   = w_ge ? w_diff[W-1:0] : w_shift[W-1:0];
        n_req.quo   = {i_req.quo[W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.valid <= 1'b0;
        end else begin
            r_req.valid <= n_req.valid;
        end
        r_req.neg <= n_req.neg;
        r_req.dz  <= n_req.dz;
        r_req.dvd <= n_req.dvd;
        r_req.dsr <= n_req.dsr;
        r_req.rem <= n_req.rem;
        r_req.quo <= n_req.quo;
    end

    assign o_req = r_req;

endmodule

@@ design/q16div_post.sv @@
`timescale 1ns / 1ps

module q16div_post (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  q16div_pkg::t_div_req                  i_req,
    output logic                                  o_done,
    output logic signed [q16div_pkg::WordW-1:0]   o_quotient,
    output logic                                  o_divide_by_zero
);

    logic                           r_done;
    logic [q16div_pkg::WordW-1:0]   r_quotient;
    logic                           r_dz;
    logic [q16div_pkg::WordW-1:0]   n_quotient;

    always_comb begin
        priority if (i_req.dz) begin
            n_quotient = '0;
        end else if (i_req.neg) begin
            n_quotient = ~i_req.quo + 1'b1;
        end else begin
            n_quotient = i_req.quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quotient <= n_quotient;
        r_dz       <= i_req.dz;
    end

    assign o_done           = r_done;
    assign o_quotient       = r_quotient;
    assign o_divide_by_zero = r_dz;

endmodule

@@ design/q16_16_signed_divider_core.sv @@
`timescale 1ns / 1ps

// Signed fixed-point divider, FRAC_BITS fraction bits (Q16.16 by default).
// A request is taken on any clock edge where start is high; busy is always low,
// so one request per cycle is sustained. Each result appears on o_quotient and
// o_divide_by_zero for exactly one cycle with o_done high, in request order.
// The receiver cannot stall the pipe and must take every result as it comes.
// The pipe is a restoring divider: one register stage per quotient bit,
// 32 + FRAC_BITS of them, plus one stage that forms operand magnitudes and one
// that applies the sign. The quotient is (|dividend| << FRAC_BITS) / |divisor|
// truncated toward zero, negated when signs differ, low 32 bits kept; -2^31 is
// taken as magnitude 2^31. A zero divisor gives quotient 0 with o_divide_by_zero.
module q16_16_signed_divider_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [q16div_pkg::WordW-1:0]   i_dividend,
    input  logic signed [q16div_pkg::WordW-1:0]   i_divisor,
    output logic                                  o_done,
    output logic signed [q16div_pkg::WordW-1:0]   o_quotient,
    output logic                                  o_divide_by_zero
);

    // One stage per bit of the widened dividend (magnitude << FRAC_BITS).
    localparam int NumSteps = q16div_pkg::WordW + FRAC_BITS;
    // Request edge to result edge.
    localparam int Latency  = NumSteps + 2;

    q16div_pkg::t_div_req w_pipe [0:NumSteps];

    // Fully pipelined, never refuses a request.
    assign busy = 1'b0;

    q16div_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (start & ~busy),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_req      (w_pipe[0])
    );

    // Trailing FRAC_BITS steps shift in zero dividend bits, giving the fraction.
    for (genvar g = 0; g < NumSteps; g++) begin : g_step
        q16div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (w_pipe[g]),
            .o_req   (w_pipe[g+1])
        );
    end

    q16div_post u_post (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (w_pipe[NumSteps]),
        .o_done           (o_done),
        .o_quotient       (o_quotient),
        .o_divide_by_zero (o_divide_by_zero)
    );

    // Every result traces back to a matching earlier request.
    a_done_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, Latency))
        else $error("result without a matching request");

    // Zero flag follows the divisor of that request.
    a_dz_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_divide_by_zero == ($past(i_divisor, Latency) == '0)))
        else $error("divide-by-zero flag mismatch");

    // A zero divisor always yields a zero quotient.
    a_dz_zero_quot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_divide_by_zero) |-> (o_quotient == '0))
        else $error("nonzero quotient on divide by zero");

    // A request on the wire always yields a result; a reset in between drops it.
    a_request_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##Latency o_done)
        else $error("request lost in pipeline");

endmodule
